[rtl/core/a64_limm_pkg.sv]
// ----------------------------------------------------------------------------
// AArch64 logical-immediate encoder package
// Field widths, the instruction class code and bit-scan helpers shared by the
// encoder pipeline.
// ----------------------------------------------------------------------------
package a64_limm_pkg;

	localparam int unsigned IMM_W     = 64;
	localparam int unsigned OP_W      = 2;
	localparam int unsigned REG_W     = 5;
	localparam int unsigned FIELD_W   = 6;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned SIZE_W    = 7;
	localparam int unsigned IN_DATA_W  = 80;
	localparam int unsigned OUT_DATA_W = 48;

	localparam logic [5:0] LOGIC_IMM_CLASS = 6'h24;

	typedef logic [SIZE_W-1:0] size_t;

	function automatic logic is_run(input logic [IMM_W-1:0] x);
		logic [IMM_W-1:0] filled;
		filled = (x - 64'd1) | x;
		return (x != '0) && (((filled + 64'd1) & filled) == '0);
	endfunction

	function automatic size_t trail_zeros(input logic [IMM_W-1:0] x);
		size_t c;
		c = size_t'(IMM_W);
		for (int i = IMM_W - 1; i >= 0; i--) begin
			if (x[i]) begin
				c = size_t'(i);
			end
		end
		return c;
	endfunction

	function automatic size_t top_bit_plus1(input logic [IMM_W-1:0] x);
		size_t c;
		c = '0;
		for (int i = 0; i < IMM_W; i++) begin
			if (x[i]) begin
				c = size_t'(i + 1);
			end
		end
		return c;
	endfunction

	// The count is summed as a balanced tree of pairwise adds.
	function automatic size_t ones_cnt(input logic [IMM_W-1:0] x);
		size_t lvl [IMM_W];
		for (int i = 0; i < IMM_W; i++) begin
			lvl[i] = size_t'(x[i]);
		end
		for (int w = int'(IMM_W / 2); w >= 1; w = w >> 1) begin
			for (int i = 0; i < w; i++) begin
				lvl[i] = lvl[2*i] + lvl[2*i+1];
			end
		end
		return lvl[0];
	endfunction

endpackage

[rtl/core/aarch64_logical_immediate_encoder.sv]
// ----------------------------------------------------------------------------
// AArch64 logical-immediate encoder
// Checks a 64-bit value for a bitmask immediate and builds N, immr, imms and
// the logical-immediate instruction word in a four-stage pipeline.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  s_axis   in         immediate, reg_wide, logic_op, dest_reg, src_reg
//  m_axis   out        encodable, n_bit, rotate_amount, size_and_length,
//                      instruction_word
//
// One beat per cycle while m_axis_tready is high; a stall at the output holds the stages.
// Stage 1 finds the element size, stage 2 tests the run, stage 3 scans the
// run position and length, stage 4 builds the fields and the word.
// Each stage holds its beat while the next one is full, so bubbles close up.
// Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module aarch64_logical_immediate_encoder
	import a64_limm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// immediate[63:0], reg_wide[64], logic_op[66:65], dest_reg[71:67],
	// src_reg[76:72], zero fill above.
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// encodable[0], n_bit[1], rotate_amount[7:2], size_and_length[13:8],
	// instruction_word[45:14], zero fill above.
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic ready_s1, ready_s2, ready_s3, ready_s4;
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	logic [IMM_W-1:0] in_imm;
	logic             in_wide;
	logic [OP_W-1:0]  in_op;
	logic [REG_W-1:0] in_rd, in_rn;
	logic [IMM_W-1:0] in_val;
	logic             in_bad;
	size_t            in_size;

	logic [IMM_W-1:0] val_s1;
	logic             bad_s1, wide_s1;
	size_t            size_s1;
	logic [OP_W-1:0]  op_s1;
	logic [REG_W-1:0] rd_s1, rn_s1;

	logic [IMM_W-1:0] el_mask, el_val, el_inv;

	logic [IMM_W-1:0] el_s2, inv_s2;
	logic             run_s2, inv_run_s2, bad_s2, wide_s2;
	size_t            size_s2;
	logic [OP_W-1:0]  op_s2;
	logic [REG_W-1:0] rd_s2, rn_s2;

	logic             ok_s3, wide_s3;
	size_t            rot_s3, ones_s3, size_s3;
	logic [OP_W-1:0]  op_s3;
	logic [REG_W-1:0] rd_s3, rn_s3;

	size_t            size_m1, immr_full;
	logic [6:0]       imms_full;
	logic [FIELD_W-1:0] immr_c, imms_c;
	logic             n_c;

	logic               ok_s4, n_s4;
	logic [FIELD_W-1:0] immr_s4, imms_s4;
	logic [WORD_W-1:0]  word_s4;

	assign ready_s4 = !valid_s4 || m_axis_tready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign s_axis_tready = ready_s1;

	assign in_imm  = s_axis_tdata[63:0];
	assign in_wide = s_axis_tdata[64];
	assign in_op   = s_axis_tdata[66:65];
	assign in_rd   = s_axis_tdata[71:67];
	assign in_rn   = s_axis_tdata[76:72];

	always_comb begin
		logic narrow_bad, degenerate;
		narrow_bad = !in_wide && (in_imm[63:32] != '0) &&
			!(in_imm[31] && (in_imm[63:32] == '1));
		in_val = in_wide ? in_imm : {32'd0, in_imm[31:0]};
		degenerate = (in_val == '0) ||
			(in_wide ? (in_val == '1) : (in_val[31:0] == '1));
		in_bad = narrow_bad || degenerate;
		if (in_wide && (in_val[31:0] != in_val[63:32])) begin
			in_size = size_t'(64);
		end else if (in_val[15:0] != in_val[31:16]) begin
			in_size = size_t'(32);
		end else if (in_val[7:0] != in_val[15:8]) begin
			in_size = size_t'(16);
		end else if (in_val[3:0] != in_val[7:4]) begin
			in_size = size_t'(8);
		end else if (in_val[1:0] != in_val[3:2]) begin
			in_size = size_t'(4);
		end else begin
			in_size = size_t'(2);
		end
	end

	assign el_mask = {IMM_W{1'b1}} >> (size_t'(IMM_W) - size_s1);
	assign el_val  = val_s1 & el_mask;
	assign el_inv  = ~val_s1 & el_mask;

	assign size_m1   = size_s3 - size_t'(1);
	assign immr_full = (size_s3 - rot_s3) & size_m1;
	assign imms_full = ({~size_m1[5:0], 1'b0} & 7'h7f) | {1'b0, 6'(ones_s3 - size_t'(1))};
	assign immr_c    = immr_full[FIELD_W-1:0];
	assign imms_c    = imms_full[FIELD_W-1:0];
	assign n_c       = !imms_full[6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && s_axis_tvalid) begin
			val_s1  <= in_val;
			bad_s1  <= in_bad;
			size_s1 <= in_size;
			wide_s1 <= in_wide;
			op_s1   <= in_op;
			rd_s1   <= in_rd;
			rn_s1   <= in_rn;
		end
		if (ready_s2 && valid_s1) begin
			el_s2      <= el_val;
			inv_s2     <= el_inv;
			run_s2     <= is_run(el_val);
			inv_run_s2 <= is_run(el_inv);
			bad_s2     <= bad_s1;
			size_s2    <= size_s1;
			wide_s2    <= wide_s1;
			op_s2      <= op_s1;
			rd_s2      <= rd_s1;
			rn_s2      <= rn_s1;
		end
		if (ready_s3 && valid_s2) begin
			ok_s3   <= !bad_s2 && (run_s2 || inv_run_s2);
			rot_s3  <= run_s2 ? trail_zeros(el_s2) : top_bit_plus1(inv_s2);
			ones_s3 <= ones_cnt(el_s2);
			size_s3 <= size_s2;
			wide_s3 <= wide_s2;
			op_s3   <= op_s2;
			rd_s3   <= rd_s2;
			rn_s3   <= rn_s2;
		end
		if (ready_s4 && valid_s3) begin
			ok_s4 <= ok_s3;
			if (ok_s3) begin
				n_s4    <= n_c;
				immr_s4 <= immr_c;
				imms_s4 <= imms_c;
				word_s4 <= {wide_s3, op_s3, LOGIC_IMM_CLASS, n_c, immr_c, imms_c,
					rn_s3, rd_s3};
			end else begin
				n_s4    <= 1'b0;
				immr_s4 <= '0;
				imms_s4 <= '0;
				word_s4 <= '0;
			end
		end
	end

	assign m_axis_tvalid = valid_s4;
	assign m_axis_tdata  = {2'b00, word_s4, imms_s4, immr_s4, n_s4, ok_s4};

endmodule
